[hw/rtl/pfa_pkg.sv]
// Package for the partition fit allocator: payload words, codes and the
// controller/datapath command and status structs. No dependencies.
package pfa_pkg;

  localparam int unsigned AmountW = 16;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned CountW  = 5;
  localparam int unsigned CfgDataW = 5;
  localparam logic [CountW-1:0] BlocksReset = 5'd16;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_REQUEST = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_NEXT  = 2'd1,
    FIT_BEST  = 2'd2,
    FIT_WORST = 2'd3
  } fit_policy_e;

  typedef enum logic {
    CFG_FIT_POLICY    = 1'b0,
    CFG_BLOCKS_IN_USE = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [IndexW-1:0]  load_index;
    logic [AmountW-1:0] amount;
  } in_word_t;

  typedef struct packed {
    logic               granted;
    logic [IndexW-1:0]  chosen_block;
    logic [AmountW-1:0] space_left;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // write a capacity from the input word
    logic start;  // capture a request, set up the scan
    logic issue;  // read one partition and step the scan
    logic wb;     // write back and fill the output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_issue;
    logic empty;
  } dp_status_t;

endpackage

[hw/rtl/partition_fit_allocator.sv]
// Top level of the partition fit allocator: joins pfa_ctrl and pfa_datapath.
// Depends on pfa_pkg.
//
//   channel  handshake               word
//   in       in_valid_i/in_ready_o   in_word_i   (load or request)
//   out      out_valid_o/out_ready_i out_word_o  (one per request)
//   cfg      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_wdata_i
//
// A load is written as it is accepted. A request passes through acceptance,
// one read of the capacity memory per partition searched, an evaluation of
// the last word and a write back. With no partition searched a request goes
// from acceptance straight to the write back.
// Reset sets first fit and a block count of 16 and clears the next-fit
// pointer and control; the capacity memory holds nothing until loaded. A full
// output register holds the write back until the word is taken.
module partition_fit_allocator #(
  parameter int unsigned MAX_BLOCKS = 16,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  pfa_pkg::in_word_t            in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output pfa_pkg::out_word_t           out_word_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  pfa_pkg::cfg_reg_e            cfg_index_i,
  input  logic [pfa_pkg::CfgDataW-1:0] cfg_wdata_i
);

  pfa_pkg::dp_cmd_t    dp_cmd;
  pfa_pkg::dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  pfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_word_i.cmd),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  pfa_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_word_i   (in_word_i),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .out_word_o  (out_word_o)
  );

endmodule

[hw/rtl/pfa_datapath.sv]
// Datapath: partition capacity memory, scan counters, fit compare, config
// registers, next-fit pointer and output word register. Uses pfa_pkg.
module pfa_datapath #(
  parameter int unsigned MAX_BLOCKS = 16,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  pfa_pkg::cfg_reg_e           cfg_index_i,
  input  logic [pfa_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  pfa_pkg::in_word_t           in_word_i,
  input  pfa_pkg::dp_cmd_t            cmd_i,
  output pfa_pkg::dp_status_t         status_o,
  output pfa_pkg::out_word_t          out_word_o
);

  localparam int unsigned IW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CNW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CW  = (SIZE_BITS > pfa_pkg::AmountW) ? SIZE_BITS : pfa_pkg::AmountW;

  pfa_pkg::fit_policy_e           policy_q;
  logic [pfa_pkg::CountW-1:0]     biu_q;
  logic [CNW-1:0]                 n_w;

  logic [SIZE_BITS-1:0]           mem_q [MAX_BLOCKS];
  logic                           mem_we;
  logic [IW-1:0]                  mem_waddr;
  logic [SIZE_BITS-1:0]           mem_wdata;

  logic [pfa_pkg::AmountW-1:0]    amount_q;
  logic [IW-1:0]                  j_q, j_d, j_next;
  logic [CNW-1:0]                 i_q, i_d, j_inc;
  logic [IW-1:0]                  ptr_q, ptr_d;
  logic [SIZE_BITS-1:0]           rd_data_q;
  logic [IW-1:0]                  rd_idx_q;
  logic                           rd_vld_q;

  logic                           found_q, found_d;
  logic [IW-1:0]                  best_idx_q, best_idx_d;
  logic [SIZE_BITS-1:0]           best_left_q, best_left_d;
  logic [CW:0]                    diff;
  logic                           fits, better;
  logic [SIZE_BITS-1:0]           left;
  pfa_pkg::out_word_t             out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= pfa_pkg::FIT_FIRST;
      biu_q    <= pfa_pkg::BlocksReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pfa_pkg::CFG_FIT_POLICY:    policy_q <= pfa_pkg::fit_policy_e'(cfg_wdata_i[1:0]);
        pfa_pkg::CFG_BLOCKS_IN_USE: biu_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign n_w = (32'(biu_q) > MAX_BLOCKS) ? CNW'(MAX_BLOCKS) : CNW'(biu_q);

  assign status_o.empty      = (n_w == '0);
  assign status_o.last_issue = (i_q == n_w - CNW'(1));

  // scan address and count
  assign j_inc  = CNW'(j_q) + CNW'(1);
  assign j_next = (j_inc == n_w) ? '0 : IW'(j_inc);

  always_comb begin
    j_d = j_q;
    i_d = i_q;
    if (cmd_i.start) begin
      i_d = '0;
      if (policy_q == pfa_pkg::FIT_NEXT && CNW'(ptr_q) < n_w) begin
        j_d = ptr_q;
      end else begin
        j_d = '0;
      end
    end else if (cmd_i.issue) begin
      j_d = j_next;
      i_d = i_q + CNW'(1);
    end
  end

  // fit evaluation on the registered read word
  assign diff = {1'b0, CW'(rd_data_q)} - {1'b0, CW'(amount_q)};
  assign fits = !diff[CW];
  assign left = diff[SIZE_BITS-1:0];

  always_comb begin
    case (policy_q)
      pfa_pkg::FIT_BEST:  better = !found_q || (left < best_left_q);
      pfa_pkg::FIT_WORST: better = !found_q || (left > best_left_q);
      default:            better = !found_q;
    endcase
  end

  always_comb begin
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_left_d = best_left_q;
    if (cmd_i.start) begin
      found_d = 1'b0;
    end else if (rd_vld_q && fits && better) begin
      found_d     = 1'b1;
      best_idx_d  = rd_idx_q;
      best_left_d = left;
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.load && 32'(in_word_i.load_index) < MAX_BLOCKS) begin
      ptr_d = '0;
    end else if (cmd_i.wb && found_q && policy_q == pfa_pkg::FIT_NEXT) begin
      ptr_d = best_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
      i_q      <= '0;
      j_q      <= '0;
    end else begin
      ptr_q    <= ptr_d;
      rd_vld_q <= cmd_i.issue;
      found_q  <= found_d;
      i_q      <= i_d;
      j_q      <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q  <= best_idx_d;
    best_left_q <= best_left_d;
    if (cmd_i.start) begin
      amount_q <= in_word_i.amount;
    end
  end

  // single write port: loads in idle, write back at the end of a request
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = best_idx_q;
    mem_wdata = best_left_q;
    if (cmd_i.load) begin
      mem_we    = 32'(in_word_i.load_index) < MAX_BLOCKS;
      mem_waddr = IW'(in_word_i.load_index);
      mem_wdata = SIZE_BITS'(in_word_i.amount);
    end else if (cmd_i.wb) begin
      mem_we = found_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.issue) begin
      rd_data_q <= mem_q[j_q];
      rd_idx_q  <= j_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wb) begin
      out_q.granted      <= found_q;
      out_q.chosen_block <= found_q ? pfa_pkg::IndexW'(best_idx_q) : '0;
      out_q.space_left   <= found_q ? pfa_pkg::AmountW'(best_left_q) : '0;
    end
  end

  assign out_word_o = out_q;

  a_issue_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> (i_q < n_w) && (CNW'(j_q) < n_w))
    else $error("scan read beyond the searched partitions");

  a_grant_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wb && found_q) |-> (CNW'(best_idx_q) < n_w))
    else $error("granted partition outside the searched range");

  a_load_clears_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && 32'(in_word_i.load_index) < MAX_BLOCKS) |=> (ptr_q == '0))
    else $error("next-fit pointer not cleared by a load");

endmodule

[hw/rtl/pfa_ctrl.sv]
// Controller: state machine sequencing loads and request scans, and the
// output valid flag. Uses pfa_pkg.
module pfa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  pfa_pkg::cmd_e       in_cmd_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  pfa_pkg::dp_status_t status_i,
  output pfa_pkg::dp_cmd_t    cmd_o
);

  pfa_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;

  assign in_ready_o  = (state_q == pfa_pkg::ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfa_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      pfa_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_cmd_i == pfa_pkg::CMD_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            state_d = status_i.empty ? pfa_pkg::ST_DONE : pfa_pkg::ST_SCAN;
          end
        end
      end
      pfa_pkg::ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (status_i.last_issue) begin
          state_d = pfa_pkg::ST_DRAIN;
        end
      end
      pfa_pkg::ST_DRAIN: begin
        state_d = pfa_pkg::ST_DONE;
      end
      pfa_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.wb = 1'b1;
          state_d  = pfa_pkg::ST_IDLE;
        end
      end
      default: state_d = pfa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.wb) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  a_req_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_cmd_i == pfa_pkg::CMD_REQUEST)
      |=> (state_q == pfa_pkg::ST_SCAN || state_q == pfa_pkg::ST_DONE))
    else $error("request did not start a scan");

  a_wb_publishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wb |=> out_valid_q)
    else $error("write back without a result word");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wb |-> (!out_valid_q || out_ready_i))
    else $error("result word overwritten before it was taken");

endmodule

[tb/partition_fit_allocator_tb.sv]
// Self-checking testbench for partition_fit_allocator: directed and random
// load/request words under all four fit policies, checked against a local model.
// Depends on pfa_pkg and the partition_fit_allocator RTL.
module partition_fit_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxBlocks   = 16;
  localparam int unsigned DrainCycles = 25;
  localparam int unsigned RandomWords = 1925;

  class grant_tracker;
    logic [pfa_pkg::AmountW-1:0] capacity [MaxBlocks];
    logic [pfa_pkg::IndexW-1:0]  nf_ptr;
    pfa_pkg::fit_policy_e        policy;
    logic [pfa_pkg::CountW-1:0]  n_blocks;
    pfa_pkg::out_word_t          pending_grants [$];
    int unsigned                 errors;

    function new();
      policy   = pfa_pkg::FIT_FIRST;
      n_blocks = pfa_pkg::BlocksReset;
      nf_ptr   = '0;
      errors   = 0;
      foreach (capacity[i]) capacity[i] = '0;
    endfunction

    function void note_fault(string what);
      errors++;
      if (errors <= 10) begin
        $display("[%0t] %s", $time, what);
      end
    endfunction

    function void set_reg(pfa_pkg::cfg_reg_e idx, logic [pfa_pkg::CfgDataW-1:0] d);
      if (idx == pfa_pkg::CFG_FIT_POLICY) begin
        policy = pfa_pkg::fit_policy_e'(d[1:0]);
      end else begin
        n_blocks = d;
      end
    endfunction

    // accepted input word: update the table, queue the expected grant
    function void note_word(pfa_pkg::in_word_t w);
      int unsigned        n, j, k, pick, left, best_left;
      bit                 found;
      pfa_pkg::out_word_t want;
      if (w.cmd == pfa_pkg::CMD_LOAD) begin
        capacity[w.load_index] = w.amount;
        nf_ptr = '0;
        return;
      end
      n = (n_blocks > MaxBlocks) ? MaxBlocks : n_blocks;
      found = 1'b0;
      pick = 0;
      best_left = 0;
      if (policy == pfa_pkg::FIT_NEXT) begin
        j = (nf_ptr < n) ? nf_ptr : 0;
        for (k = 0; k < n; k++) begin
          if (!found && capacity[j] >= w.amount) begin
            found = 1'b1;
            pick = j;
          end
          j = (j + 1 == n) ? 0 : j + 1;
        end
      end else begin
        for (k = 0; k < n; k++) begin
          if (capacity[k] >= w.amount) begin
            left = capacity[k] - w.amount;
            if (!found || (policy == pfa_pkg::FIT_BEST && left < best_left) ||
                (policy == pfa_pkg::FIT_WORST && left > best_left)) begin
              found = 1'b1;
              pick = k;
              best_left = left;
            end
          end
        end
      end
      want = '0;
      if (found) begin
        capacity[pick] = capacity[pick] - w.amount;
        if (policy == pfa_pkg::FIT_NEXT) nf_ptr = pick[pfa_pkg::IndexW-1:0];
        want.granted      = 1'b1;
        want.chosen_block = pick[pfa_pkg::IndexW-1:0];
        want.space_left   = capacity[pick];
      end
      pending_grants.push_back(want);
    endfunction

    function void check_word(pfa_pkg::out_word_t got);
      pfa_pkg::out_word_t want;
      if (pending_grants.size() == 0) begin
        note_fault($sformatf("unexpected word: granted=%0d block=%0d left=%0d",
                             got.granted, got.chosen_block, got.space_left));
        return;
      end
      want = pending_grants.pop_front();
      if (got.granted !== want.granted || got.chosen_block !== want.chosen_block ||
          got.space_left !== want.space_left) begin
        note_fault($sformatf(
          "mismatch: expected granted=%0d block=%0d left=%0d, got granted=%0d block=%0d left=%0d",
          want.granted, want.chosen_block, want.space_left,
          got.granted, got.chosen_block, got.space_left));
      end
    endfunction

    function int unsigned pending_count();
      return pending_grants.size();
    endfunction

    function void close_out();
      pfa_pkg::out_word_t want;
      while (pending_grants.size() != 0) begin
        want = pending_grants.pop_front();
        note_fault($sformatf("missing word: granted=%0d block=%0d left=%0d",
                             want.granted, want.chosen_block, want.space_left));
      end
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_ready_o;
  pfa_pkg::in_word_t            in_word_i   = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  pfa_pkg::out_word_t           out_word_o;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  pfa_pkg::cfg_reg_e            cfg_index_i = pfa_pkg::CFG_FIT_POLICY;
  logic [pfa_pkg::CfgDataW-1:0] cfg_wdata_i = '0;

  grant_tracker ledger = new();
  int unsigned  burst_left = 0;

  partition_fit_allocator #(
    .MAX_BLOCKS(MaxBlocks),
    .SIZE_BITS (pfa_pkg::AmountW)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) ledger.check_word(out_word_o);
  end

  // receiver: stretches of free flow, random stalls and long stalls
  initial begin
    int unsigned mode;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 200)) begin
        @(posedge clk_i);
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 7) != 0);
          default: out_ready_i <= ($urandom_range(0, 15) == 0);
        endcase
      end
    end
  end

  task automatic send_word(input pfa_pkg::in_word_t w);
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    ledger.note_word(w);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
  endtask

  task automatic load_word(input logic [pfa_pkg::IndexW-1:0] idx,
                           input logic [pfa_pkg::AmountW-1:0] cap);
    pfa_pkg::in_word_t w;
    w.cmd        = pfa_pkg::CMD_LOAD;
    w.load_index = idx;
    w.amount     = cap;
    send_word(w);
  endtask

  task automatic request_word(input logic [pfa_pkg::AmountW-1:0] size);
    pfa_pkg::in_word_t w;
    w.cmd        = pfa_pkg::CMD_REQUEST;
    w.load_index = 4'($urandom_range(0, 15));
    w.amount     = size;
    send_word(w);
  endtask

  // stop sending, let every grant arrive and the last load settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (ledger.pending_count() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_regs(input pfa_pkg::fit_policy_e pol,
                          input logic [pfa_pkg::CfgDataW-1:0] blk);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= pfa_pkg::CFG_FIT_POLICY;
    cfg_wdata_i <= pfa_pkg::CfgDataW'(pol);
    do @(posedge clk_i); while (!cfg_ready_o);
    ledger.set_reg(pfa_pkg::CFG_FIT_POLICY, pfa_pkg::CfgDataW'(pol));
    cfg_index_i <= pfa_pkg::CFG_BLOCKS_IN_USE;
    cfg_wdata_i <= blk;
    do @(posedge clk_i); while (!cfg_ready_o);
    ledger.set_reg(pfa_pkg::CFG_BLOCKS_IN_USE, blk);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [pfa_pkg::AmountW-1:0]  caps [MaxBlocks];
    pfa_pkg::fit_policy_e         pol;
    logic [pfa_pkg::CfgDataW-1:0] blk;
    logic [pfa_pkg::AmountW-1:0]  top;
    pfa_pkg::in_word_t            w;
    int unsigned                  sent;

    caps = '{100, 50, 65535, 50, 0, 200, 50, 100, 7, 300, 1000, 50, 65535, 20, 0, 40000};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every partition is loaded before the first request
    for (int i = 0; i < MaxBlocks; i++) load_word(4'(i), caps[i]);
    request_word(16'd0);
    request_word(16'hFFFF);
    request_word(16'hFFFF);
    set_regs(pfa_pkg::FIT_BEST, 5'd16);
    request_word(16'd50);
    request_word(16'd95);
    set_regs(pfa_pkg::FIT_WORST, 5'd16);
    request_word(16'd0);
    set_regs(pfa_pkg::FIT_NEXT, 5'd16);
    request_word(16'd30000);
    request_word(16'd100);
    // pointer now past the block count
    set_regs(pfa_pkg::FIT_NEXT, 5'd4);
    request_word(16'd1);
    set_regs(pfa_pkg::FIT_FIRST, 5'd0);
    request_word(16'd0);
    set_regs(pfa_pkg::FIT_WORST, 5'd31);
    request_word(16'd0);

    sent = 0;
    while (sent < RandomWords) begin
      pol = pfa_pkg::fit_policy_e'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0:       blk = 5'd0;
        1:       blk = 5'd1;
        2:       blk = 5'($urandom_range(17, 31));
        3, 4:    blk = 5'd16;
        default: blk = 5'($urandom_range(2, 15));
      endcase
      set_regs(pol, blk);
      case ($urandom_range(0, 2))
        0:       top = 16'd15;
        1:       top = 16'd1023;
        default: top = 16'hFFFF;
      endcase
      repeat ($urandom_range(40, 160)) begin
        w.cmd = ($urandom_range(0, 9) < 3) ? pfa_pkg::CMD_LOAD : pfa_pkg::CMD_REQUEST;
        w.load_index = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 15))
          0:       w.amount = '0;
          1:       w.amount = top;
          2:       w.amount = 16'hFFFF;
          default: w.amount = 16'($urandom_range(0, top));
        endcase
        send_word(w);
        sent++;
      end
    end

    drain();
    ledger.close_out();
    if (ledger.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[files.f]
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_datapath.sv
hw/rtl/pfa_ctrl.sv
hw/rtl/partition_fit_allocator.sv
tb/partition_fit_allocator_tb.sv
